// File: src/battery_presence_monitor_assert.svh
// ----------------------------------------------------------------------------
// Battery presence monitor assertion macros
// Concurrent check wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_PRESENCE_MONITOR_ASSERT_SVH
`define BATTERY_PRESENCE_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define BPM_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("battery_presence_monitor: check failed");
// next-cycle implication
`define BPM_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("battery_presence_monitor: check failed");
`else
`define BPM_ASSERT_IMP(lbl, ant, con)
`define BPM_ASSERT_NXT(lbl, ant, con)
`endif

`endif

// File: src/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the battery presence monitor.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // one poll sample
  typedef struct packed {
    logic              present;
    logic              auth_ok;
    logic              charging;
    logic signed [15:0] current_ma;
    logic [6:0]        battery_percent;
    logic signed [7:0] temperature;
  } in_t;

  // one result
  typedef struct packed {
    logic [2:0] battery_state;
    logic       report_status;
    logic       discharge_alarm;
    logic       removal_event;
    logic       insertion_event;
  } out_t;

  typedef struct packed {
    logic [3:0] bad_sample_limit;
    logic [7:0] discharge_limit;
    logic [3:0] temp_delta;
  } cfg_t;

  // register indexes
  localparam logic [1:0] CFG_IDX_BAD_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_IDX_DISCH_LIM  = 2'd1;
  localparam logic [1:0] CFG_IDX_TEMP_DELTA = 2'd2;

  // reset values
  localparam logic [3:0] BAD_LIMIT_RST  = 4'd3;
  localparam logic [7:0] DISCH_LIM_RST  = 8'd25;
  localparam logic [3:0] TEMP_DELTA_RST = 4'd1;

  // reported state codes
  localparam logic [2:0] BS_REMOVED   = 3'd0;
  localparam logic [2:0] BS_DEBOUNCE  = 3'd1;
  localparam logic [2:0] BS_INSERTED  = 3'd2;
  localparam logic [2:0] BS_AUTHENTIC = 3'd3;
  localparam logic [2:0] BS_NOTAUTH   = 3'd4;

endpackage

// File: src/bpm_cfg.sv
// ----------------------------------------------------------------------------
// bpm_cfg
// Configuration register file with a valid/ready write channel.
// ----------------------------------------------------------------------------
module bpm_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output bpm_pkg::cfg_t    cfg
);

  bpm_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bpm_pkg::CFG_IDX_BAD_LIMIT:  cfg_nxt.bad_sample_limit = cfg_data[3:0];
        bpm_pkg::CFG_IDX_DISCH_LIM:  cfg_nxt.discharge_limit  = cfg_data;
        bpm_pkg::CFG_IDX_TEMP_DELTA: cfg_nxt.temp_delta       = cfg_data[3:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bad_sample_limit <= bpm_pkg::BAD_LIMIT_RST;
      cfg_r.discharge_limit  <= bpm_pkg::DISCH_LIM_RST;
      cfg_r.temp_delta       <= bpm_pkg::TEMP_DELTA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/bpm_fsm.sv
// ----------------------------------------------------------------------------
// bpm_fsm
// Presence state machine, debounce and discharge counters, report filter.
// Resolves the whole transition chain for one sample in a single pass.
// ----------------------------------------------------------------------------
module bpm_fsm (
  input  logic           clk,
  input  logic           rst_n,
  input  bpm_pkg::cfg_t  cfg,
  input  bpm_pkg::in_t   smp,
  input  logic           adv,
  output bpm_pkg::out_t  res
);

  typedef enum logic [4:0] {
    ST_REMOVED   = 5'b00001,
    ST_DEBOUNCE  = 5'b00010,
    ST_INSERTED  = 5'b00100,
    ST_AUTHENTIC = 5'b01000,
    ST_NOTAUTH   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        bad_r, bad_nxt;
  logic [7:0]        run_r, run_nxt;
  logic [6:0]        last_pct_r, last_pct_nxt;
  logic signed [7:0] last_temp_r, last_temp_nxt;

  logic is_rem, is_deb, is_ins, is_na, is_au;
  logic p;
  logic common_run, deb_run;
  logic [4:0] bad_inc;
  logic over;
  logic dis_cond;
  logic [7:0] run_inc;
  logic alarm, report, removal, insertion;
  logic signed [8:0] tdiff;
  logic [8:0] tabs;

  always_comb begin
    is_rem = 1'b0;
    is_deb = 1'b0;
    is_ins = 1'b0;
    is_na  = 1'b0;
    is_au  = 1'b0;
    unique case (state_r)
      ST_REMOVED:   is_rem = 1'b1;
      ST_DEBOUNCE:  is_deb = 1'b1;
      ST_INSERTED:  is_ins = 1'b1;
      ST_AUTHENTIC: is_au  = 1'b1;
      ST_NOTAUTH:   is_na  = 1'b1;
      default:      is_deb = 1'b1;
    endcase
  end

  assign p = smp.present;

  // present: chain always ends in the auth/not-auth check.
  // absent: anything past removed falls back through debounce.
  assign common_run = p | is_ins | is_na | is_au;
  assign deb_run    = ~p & ~is_rem;
  assign insertion  = is_ins | (p & (is_rem | is_deb));

  assign bad_inc = {1'b0, bad_r} + 5'd1;
  assign over    = bad_inc > {1'b0, cfg.bad_sample_limit};
  assign removal = deb_run & over;

  assign dis_cond = smp.charging & (smp.current_ma[15] | (smp.current_ma == 16'sd0));
  assign run_inc  = run_r + 8'd1;
  assign alarm    = common_run & dis_cond & (cfg.discharge_limit != 8'd0)
                    & (run_inc == cfg.discharge_limit);

  assign tdiff  = {smp.temperature[7], smp.temperature} - {last_temp_r[7], last_temp_r};
  assign tabs   = tdiff[8] ? 9'(-tdiff) : 9'(tdiff);
  assign report = p & ((smp.battery_percent != last_pct_r) | (tabs > {5'd0, cfg.temp_delta}));

  always_comb begin
    bad_nxt       = bad_r;
    run_nxt       = run_r;
    last_pct_nxt  = last_pct_r;
    last_temp_nxt = last_temp_r;

    if (p & is_deb) begin
      bad_nxt = 4'd0;
    end else if (deb_run) begin
      bad_nxt = over ? 4'd0 : bad_inc[3:0];
    end

    if (common_run) begin
      if (dis_cond) begin
        run_nxt = alarm ? 8'd0 : run_inc;
      end else begin
        run_nxt = 8'd0;
      end
    end

    if (report) begin
      last_pct_nxt  = smp.battery_percent;
      last_temp_nxt = smp.temperature;
    end

    if (p) begin
      state_nxt = (is_au | smp.auth_ok) ? ST_AUTHENTIC : ST_NOTAUTH;
    end else if (is_rem | over) begin
      state_nxt = ST_REMOVED;
    end else begin
      state_nxt = ST_DEBOUNCE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DEBOUNCE;
      bad_r       <= 4'd0;
      run_r       <= 8'd0;
      last_pct_r  <= 7'd0;
      last_temp_r <= 8'sd0;
    end else if (adv) begin
      state_r     <= state_nxt;
      bad_r       <= bad_nxt;
      run_r       <= run_nxt;
      last_pct_r  <= last_pct_nxt;
      last_temp_r <= last_temp_nxt;
    end
  end

  always_comb begin
    unique case (state_nxt)
      ST_REMOVED:   res.battery_state = bpm_pkg::BS_REMOVED;
      ST_DEBOUNCE:  res.battery_state = bpm_pkg::BS_DEBOUNCE;
      ST_INSERTED:  res.battery_state = bpm_pkg::BS_INSERTED;
      ST_AUTHENTIC: res.battery_state = bpm_pkg::BS_AUTHENTIC;
      ST_NOTAUTH:   res.battery_state = bpm_pkg::BS_NOTAUTH;
      default:      res.battery_state = bpm_pkg::BS_DEBOUNCE;
    endcase
  end

  assign res.report_status   = report;
  assign res.discharge_alarm = alarm;
  assign res.removal_event   = removal;
  assign res.insertion_event = insertion;

endmodule

// File: src/battery_presence_monitor.sv
// Path: an accepted sample waits in the input register and moves to the output register once the output is free.
// Throughput: one sample per cycle while the output is not stalled; an input register and an output register
// bracket a single combinational pass through the state machine.
// Reset (rst_n low, synchronous): state debounce, counters and last-report
// values zero, registers 3 / 25 / 1, both pipeline stages empty.
// ----------------------------------------------------------------------------
// battery_presence_monitor
// Battery poll monitor: presence/auth state machine, discharge alarm, reporting.
// ----------------------------------------------------------------------------
module battery_presence_monitor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bpm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  bpm_pkg::cfg_t cfg;
  bpm_pkg::in_t  s1_data_r;
  bpm_pkg::out_t out_data_r;
  bpm_pkg::out_t res;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, adv, in_accept;

  bpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpm_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .smp   (s1_data_r),
    .adv   (adv),
    .res   (res)
  );

  assign out_free  = ~out_valid_r | ~out_stall;
  assign adv       = s1_valid_r & out_free;
  assign in_stall  = s1_valid_r & ~out_free;
  assign in_accept = in_valid & ~in_stall;

  assign s1_valid_nxt  = in_accept | (s1_valid_r & ~adv);
  assign out_valid_nxt = adv | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "battery_presence_monitor_assert.svh"

  `BPM_ASSERT_IMP(a_removal_state, out_valid_r && out_data_r.removal_event,
    out_data_r.battery_state == bpm_pkg::BS_REMOVED)
  `BPM_ASSERT_IMP(a_report_state, out_valid_r && out_data_r.report_status,
    out_data_r.battery_state == bpm_pkg::BS_AUTHENTIC ||
    out_data_r.battery_state == bpm_pkg::BS_NOTAUTH)
  `BPM_ASSERT_IMP(a_inserted_transient, out_valid_r,
    out_data_r.battery_state != bpm_pkg::BS_INSERTED)
  `BPM_ASSERT_NXT(a_result_follows, adv, out_valid_r)

endmodule
